// ===== design/pmc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared types and constants for the power mode controller: mode codes,
// CAN command codes, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package pmc_pkg;

    // Power mode codes
    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_INIT   = 3'd1,
        MODE_ACTIVE = 3'd2,
        MODE_LOW    = 3'd3,
        MODE_SLEEP  = 3'd4,
        MODE_FAULT  = 3'd5
    } mode_t;

    // CAN command codes
    typedef enum logic [1:0] {
        CMD_NONE        = 2'd0,
        CMD_WAKEUP      = 2'd1,
        CMD_SLEEP       = 2'd2,
        CMD_RESET_FAULT = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FAULT_THR     = 2'd0,
        CFG_LOW_THR       = 2'd1,
        CFG_TICK_PERIOD   = 2'd2,
        CFG_SLEEP_TIMEOUT = 2'd3
    } cfg_idx_t;

    localparam int MV_W    = 16;
    localparam int TICK_W  = 10;
    localparam int TMO_W   = 16;
    localparam int SLEEP_W = 17;
    localparam int CFG_W   = 16;

    localparam logic [MV_W-1:0]    FAULT_THR_RST     = 16'd9000;
    localparam logic [MV_W-1:0]    LOW_THR_RST       = 16'd11500;
    localparam logic [TICK_W-1:0]  TICK_PERIOD_RST   = 10'd10;
    localparam logic [TMO_W-1:0]   SLEEP_TIMEOUT_RST = 16'd5000;
    localparam logic [SLEEP_W-1:0] SLEEP_MAX         = {SLEEP_W{1'b1}};

endpackage

// ===== design/power_mode_controller_core.sv =====
// ----------------------------------------------------------------------------
// power_mode_controller_core
// Six-state vehicle power mode controller. One request per task tick; a
// sticky battery-fault latch, a sleep timer and the mode are updated per tick.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | ign_on .. can_command
//  out     | output    | out_valid / out_ready| power_mode .. battery_fault
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A request is registered in the input stage on acceptance and then evaluated
//  into the result register; one request per cycle is sustained unless stalled.
//  Mode, sleep timer and fault latch update when the request moves to the
//  result register. Reset returns the mode to off and the registers to their
//  defaults. A stalled result holds the input stage until it drains.
// ----------------------------------------------------------------------------
module power_mode_controller_core (
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      ign_on,
    input  logic                      wakeup_req,
    input  logic [pmc_pkg::MV_W-1:0]  battery_mv,
    input  logic                      can_timeout,
    input  logic                      internal_fault,
    input  logic                      init_done,
    input  logic [1:0]                can_command,
    // result channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2:0]                power_mode,
    output logic                      peripheral_enable,
    output logic                      camera_enable,
    output logic                      battery_fault,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [pmc_pkg::CFG_W-1:0] cfg_data
);
    import pmc_pkg::*;

    // configuration registers
    logic [MV_W-1:0]    fault_thr_reg;
    logic [MV_W-1:0]    low_thr_reg;
    logic [TICK_W-1:0]  tick_period_reg;
    logic [TMO_W-1:0]   sleep_timeout_reg;

    // input stage
    logic               s1_valid_reg;
    logic               s1_ign_reg;
    logic               s1_wake_reg;
    logic [MV_W-1:0]    s1_bat_reg;
    logic               s1_cto_reg;
    logic               s1_ifault_reg;
    logic               s1_init_done_reg;
    cmd_t               s1_cmd_reg;

    // controller state and result register
    mode_t              mode_reg,  mode_next;
    logic [SLEEP_W-1:0] sleep_reg, sleep_next;
    logic               latch_reg, latch_next;
    logic               out_valid_reg;
    logic               periph_reg, periph_next;
    logic               camera_reg, camera_next;

    logic               advance;
    logic               accept_in;
    logic               cto_eff;
    logic               ifault_eff;
    logic               any_fault;
    mode_t              mode_cmd;
    logic [SLEEP_W:0]   sleep_sum;
    logic [SLEEP_W-1:0] sleep_sat;

    // handshakes
    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign accept_in = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_thr_reg     <= FAULT_THR_RST;
            low_thr_reg       <= LOW_THR_RST;
            tick_period_reg   <= TICK_PERIOD_RST;
            sleep_timeout_reg <= SLEEP_TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FAULT_THR:     fault_thr_reg     <= cfg_data[MV_W-1:0];
                CFG_LOW_THR:       low_thr_reg       <= cfg_data[MV_W-1:0];
                CFG_TICK_PERIOD:   tick_period_reg   <= cfg_data[TICK_W-1:0];
                CFG_SLEEP_TIMEOUT: sleep_timeout_reg <= cfg_data[TMO_W-1:0];
                default:           ;
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_ign_reg       <= ign_on;
            s1_wake_reg      <= wakeup_req;
            s1_bat_reg       <= battery_mv;
            s1_cto_reg       <= can_timeout;
            s1_ifault_reg    <= internal_fault;
            s1_init_done_reg <= init_done;
            s1_cmd_reg       <= cmd_t'(can_command);
        end
    end

    // saturating sleep timer sum
    assign sleep_sum = {1'b0, sleep_reg} + {{(SLEEP_W+1-TICK_W){1'b0}}, tick_period_reg};
    assign sleep_sat = sleep_sum[SLEEP_W] ? SLEEP_MAX : sleep_sum[SLEEP_W-1:0];

    // one tick: battery latch, then CAN command, then mode case
    always_comb
    begin
        latch_next  = latch_reg || (s1_bat_reg < fault_thr_reg);
        mode_cmd    = mode_reg;
        sleep_next  = sleep_reg;
        cto_eff     = s1_cto_reg;
        ifault_eff  = s1_ifault_reg;
        periph_next = 1'b0;
        camera_next = 1'b0;

        // CAN command
        case (s1_cmd_reg)
            CMD_WAKEUP:
            begin
                if (mode_reg == MODE_OFF || mode_reg == MODE_SLEEP)
                begin
                    mode_cmd   = MODE_INIT;
                    sleep_next = '0;
                end
            end
            CMD_RESET_FAULT:
            begin
                if (mode_reg == MODE_FAULT)
                begin
                    latch_next = 1'b0;
                    cto_eff    = 1'b0;
                    ifault_eff = 1'b0;
                    mode_cmd   = MODE_INIT;
                end
            end
            default: ;
        endcase

        any_fault = latch_next || cto_eff || ifault_eff;
        mode_next = mode_cmd;

        // mode case on the updated mode
        unique case (mode_cmd)
            MODE_OFF:
            begin
                if (s1_ign_reg || s1_wake_reg)
                    mode_next = MODE_INIT;
            end
            MODE_INIT:
            begin
                if (s1_init_done_reg)
                    mode_next = MODE_ACTIVE;
            end
            MODE_ACTIVE:
            begin
                periph_next = 1'b1;
                camera_next = 1'b1;
                if (any_fault)
                    mode_next = MODE_FAULT;
                else if (s1_bat_reg >= fault_thr_reg && s1_bat_reg < low_thr_reg)
                    mode_next = MODE_LOW;
                else if (!s1_ign_reg)
                begin
                    mode_next  = MODE_SLEEP;
                    sleep_next = '0;
                end
            end
            MODE_LOW:
            begin
                periph_next = 1'b1;
                if (any_fault)
                    mode_next = MODE_FAULT;
                else if (s1_bat_reg >= low_thr_reg)
                    mode_next = MODE_ACTIVE;
            end
            MODE_SLEEP:
            begin
                if (s1_wake_reg || s1_ign_reg)
                begin
                    mode_next  = MODE_INIT;
                    sleep_next = '0;
                end
                else if (sleep_sat >= {1'b0, sleep_timeout_reg})
                begin
                    mode_next  = MODE_OFF;
                    sleep_next = '0;
                end
                else
                    sleep_next = sleep_sat;
            end
            default: ;
        endcase
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OFF;
            sleep_reg     <= '0;
            latch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            periph_reg    <= 1'b0;
            camera_reg    <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg      <= mode_next;
            sleep_reg     <= sleep_next;
            latch_reg     <= latch_next;
            out_valid_reg <= 1'b1;
            periph_reg    <= periph_next;
            camera_reg    <= camera_next;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid         = out_valid_reg;
    assign power_mode        = mode_reg;
    assign peripheral_enable = periph_reg;
    assign camera_enable     = camera_reg;
    assign battery_fault     = latch_reg;

endmodule

// ===== design/pmc_checker.sv =====
// ----------------------------------------------------------------------------
// pmc_checker
// Port-level checks for the power mode controller, bound to the top level.
// ----------------------------------------------------------------------------
module pmc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] power_mode,
    input logic       peripheral_enable,
    input logic       camera_enable,
    input logic       battery_fault
);
    import pmc_pkg::*;

    // camera power always comes with peripheral power
    a_cam_periph: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && camera_enable |-> peripheral_enable)
        else $error("camera enabled without peripheral power");

    // camera only in the active case, which never ends in off or init
    a_cam_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && camera_enable |->
            (power_mode == MODE_ACTIVE || power_mode == MODE_LOW ||
             power_mode == MODE_SLEEP || power_mode == MODE_FAULT))
        else $error("camera enabled with mode off or init");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(power_mode) && $stable(peripheral_enable) &&
            $stable(camera_enable) && $stable(battery_fault))
        else $error("result changed while stalled");

endmodule

bind power_mode_controller_core pmc_checker u_pmc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .power_mode        (power_mode),
    .peripheral_enable (peripheral_enable),
    .camera_enable     (camera_enable),
    .battery_fault     (battery_fault)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for power_mode_controller_core. Requests go through
// a directed table first, then through random phases with different threshold
// and timer settings. A bit-accurate mode predictor runs on every accepted
// request; each result is checked in order against it or a hand-written result.
// ----------------------------------------------------------------------------
module tb_top;
    import pmc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_REQS  = 50;

    // One tick of sampled signal levels
    typedef struct packed {
        logic        ign;
        logic        wake;
        logic [15:0] bat;
        logic        cto;
        logic        ifl;
        logic        idn;
        cmd_t        cmd;
    } tick_t;

    // Result fields
    typedef struct packed {
        mode_t mode;
        logic  periph;
        logic  cam;
        logic  bfault;
    } result_t;

    // Directed table row: a register write or a request, optionally with a
    // hand-written result
    typedef struct {
        bit          is_cfg;
        cfg_idx_t    idx;
        logic [15:0] data;
        tick_t       tk;
        bit          typed;
        result_t     res;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid;
    logic              in_ready;
    logic              ign_on;
    logic              wakeup_req;
    logic [MV_W-1:0]   battery_mv;
    logic              can_timeout;
    logic              internal_fault;
    logic              init_done;
    logic [1:0]        can_command;
    logic              out_valid;
    logic              out_ready;
    logic [2:0]        power_mode;
    logic              peripheral_enable;
    logic              camera_enable;
    logic              battery_fault;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    // Predictor state and register copies
    mode_t        cur_mode;
    logic [16:0]  sleep_ms;
    logic         bat_latch;
    logic [15:0]  thr_fault;
    logic [15:0]  thr_low;
    logic [9:0]   tick_ms;
    logic [15:0]  tmo_ms;

    result_t   mode_outputs_q[$];
    plan_row_t plan[$];
    int        err_cnt = 0;
    int        idle_cycles = 0;
    bit        src_idle_on = 1'b1;
    bit        snk_idle_on = 1'b1;

    power_mode_controller_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .ign_on            (ign_on),
        .wakeup_req        (wakeup_req),
        .battery_mv        (battery_mv),
        .can_timeout       (can_timeout),
        .internal_fault    (internal_fault),
        .init_done         (init_done),
        .can_command       (can_command),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .power_mode        (power_mode),
        .peripheral_enable (peripheral_enable),
        .camera_enable     (camera_enable),
        .battery_fault     (battery_fault),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #10 clk = ~clk;

    // Advance the predicted controller by one tick
    function automatic result_t power_tick(tick_t tk);
        result_t     r;
        logic        cto;
        logic        ifl;
        logic        any_fault;
        logic [17:0] sum;
        cto = tk.cto;
        ifl = tk.ifl;
        r.periph = 1'b0;
        r.cam = 1'b0;
        // battery sample first, latch is sticky
        if (tk.bat < thr_fault)
            bat_latch = 1'b1;
        // CAN command on the current mode
        if (tk.cmd == CMD_WAKEUP)
        begin
            if (cur_mode == MODE_OFF || cur_mode == MODE_SLEEP)
            begin
                cur_mode = MODE_INIT;
                sleep_ms = '0;
            end
        end
        else if (tk.cmd == CMD_RESET_FAULT && cur_mode == MODE_FAULT)
        begin
            bat_latch = 1'b0;
            cto = 1'b0;
            ifl = 1'b0;
            cur_mode = MODE_INIT;
        end
        any_fault = bat_latch | cto | ifl;
        // mode case on the updated mode
        case (cur_mode)
            MODE_OFF:
            begin
                if (tk.ign || tk.wake)
                    cur_mode = MODE_INIT;
            end
            MODE_INIT:
            begin
                if (tk.idn)
                    cur_mode = MODE_ACTIVE;
            end
            MODE_ACTIVE:
            begin
                r.periph = 1'b1;
                r.cam = 1'b1;
                if (any_fault)
                    cur_mode = MODE_FAULT;
                else if (tk.bat >= thr_fault && tk.bat < thr_low)
                    cur_mode = MODE_LOW;
                else if (!tk.ign)
                begin
                    cur_mode = MODE_SLEEP;
                    sleep_ms = '0;
                end
            end
            MODE_LOW:
            begin
                r.periph = 1'b1;
                if (any_fault)
                    cur_mode = MODE_FAULT;
                else if (tk.bat >= thr_low)
                    cur_mode = MODE_ACTIVE;
            end
            MODE_SLEEP:
            begin
                if (tk.wake || tk.ign)
                begin
                    cur_mode = MODE_INIT;
                    sleep_ms = '0;
                end
                else
                begin
                    // saturating timer
                    sum = {1'b0, sleep_ms} + {8'd0, tick_ms};
                    sleep_ms = (sum > {1'b0, SLEEP_MAX}) ? SLEEP_MAX : sum[16:0];
                    if (sleep_ms >= {1'b0, tmo_ms})
                    begin
                        cur_mode = MODE_OFF;
                        sleep_ms = '0;
                    end
                end
            end
            default: ;
        endcase
        r.mode = cur_mode;
        r.bfault = bat_latch;
        return r;
    endfunction

    function automatic tick_t mk(logic ign, logic wake, logic [15:0] bat, logic cto,
                                 logic ifl, logic idn, cmd_t cmd);
        tick_t t;
        t.ign = ign;
        t.wake = wake;
        t.bat = bat;
        t.cto = cto;
        t.ifl = ifl;
        t.idn = idn;
        t.cmd = cmd;
        return t;
    endfunction

    function automatic result_t res(mode_t m, logic p, logic c, logic f);
        result_t r;
        r.mode = m;
        r.periph = p;
        r.cam = c;
        r.bfault = f;
        return r;
    endfunction

    function automatic plan_row_t row_chk(tick_t tk, result_t r);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.idx = CFG_FAULT_THR;
        row.data = '0;
        row.tk = tk;
        row.typed = 1'b1;
        row.res = r;
        return row;
    endfunction

    function automatic plan_row_t row_run(tick_t tk);
        plan_row_t row;
        row = row_chk(tk, res(MODE_OFF, 1'b0, 1'b0, 1'b0));
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic plan_row_t row_cfg(cfg_idx_t idx, logic [15:0] data);
        plan_row_t row;
        row = row_run(mk(1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, CMD_NONE));
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    // Random tick, shaped by the predicted mode so that sequences get deep
    function automatic tick_t draw_tick();
        tick_t       t;
        logic [15:0] bat;
        case ($urandom_range(0, 19))
            0: bat = thr_fault - 16'd1;
            1: bat = thr_fault;
            2: bat = thr_low - 16'd1;
            3: bat = thr_low;
            4: bat = 16'($urandom_range(0, 65535));
            5: bat = 16'($urandom_range(thr_fault, thr_low));
            default: bat = 16'($urandom_range(thr_low, 65535));
        endcase
        t.bat = bat;
        t.cto = ($urandom_range(0, 99) < 3);
        t.ifl = ($urandom_range(0, 99) < 3);
        t.idn = 1'($urandom_range(0, 1));
        case (cur_mode)
            MODE_ACTIVE, MODE_LOW:
            begin
                t.ign = ($urandom_range(0, 99) < 85);
                t.wake = ($urandom_range(0, 99) < 20);
            end
            MODE_SLEEP:
            begin
                t.ign = ($urandom_range(0, 99) < 10);
                t.wake = ($urandom_range(0, 99) < 5);
            end
            default:
            begin
                t.ign = 1'($urandom_range(0, 1));
                t.wake = ($urandom_range(0, 99) < 20);
            end
        endcase
        if (cur_mode == MODE_FAULT && $urandom_range(0, 99) < 40)
            t.cmd = CMD_RESET_FAULT;
        else if (cur_mode == MODE_SLEEP)
            t.cmd = ($urandom_range(0, 99) < 5) ? CMD_WAKEUP : CMD_NONE;
        else if ($urandom_range(0, 99) < 70)
            t.cmd = CMD_NONE;
        else
            t.cmd = cmd_t'($urandom_range(0, 3));
        // some pure noise
        if ($urandom_range(0, 9) == 0)
            t = tick_t'($urandom);
        return t;
    endfunction

    // Offer one request, predict it on acceptance
    task automatic send(tick_t tk, bit typed, result_t typed_res);
        int unsigned gap;
        result_t     want;
        gap = src_idle_on ? $urandom_range(0, 10) : 0;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ign_on <= tk.ign;
        wakeup_req <= tk.wake;
        battery_mv <= tk.bat;
        can_timeout <= tk.cto;
        internal_fault <= tk.ifl;
        init_done <= tk.idn;
        can_command <= tk.cmd;
        do @(posedge clk); while (!in_ready);
        want = power_tick(tk);
        if (typed)
            want = typed_res;
        mode_outputs_q.push_back(want);
    endtask

    // Hold off requests and writes until every result is back and the pipe
    // is empty
    task automatic drain();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (mode_outputs_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write; caller lowers cfg_valid
    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_FAULT_THR:     thr_fault = val;
            CFG_LOW_THR:       thr_low = val;
            CFG_TICK_PERIOD:   tick_ms = val[9:0];
            CFG_SLEEP_TIMEOUT: tmo_ms = val;
            default: ;
        endcase
    endtask

    // Result receiver with random stalls
    initial
    begin
        int unsigned gap;
        out_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = snk_idle_on ? $urandom_range(0, 10) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Result checker
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (mode_outputs_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result: mode=%0d pe=%0b ce=%0b bf=%0b",
                             power_mode, peripheral_enable, camera_enable, battery_fault);
            end
            else
            begin
                want = mode_outputs_q.pop_front();
                if (power_mode !== want.mode || peripheral_enable !== want.periph ||
                    camera_enable !== want.cam || battery_fault !== want.bfault)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: exp m=%0d p=%0b c=%0b f=%0b got m=%0d p=%0b c=%0b f=%0b",
                                 want.mode, want.periph, want.cam, want.bfault,
                                 power_mode, peripheral_enable, camera_enable, battery_fault);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [15:0] f_thr;
        logic [15:0] l_thr;
        logic [15:0] t_per;
        logic [15:0] t_out;
        in_valid <= 1'b0;
        ign_on <= 1'b0;
        wakeup_req <= 1'b0;
        battery_mv <= '0;
        can_timeout <= 1'b0;
        internal_fault <= 1'b0;
        init_done <= 1'b0;
        can_command <= CMD_NONE;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FAULT_THR;
        cfg_data <= '0;

        // reset state of the predictor
        cur_mode = MODE_OFF;
        sleep_ms = '0;
        bat_latch = 1'b0;
        thr_fault = FAULT_THR_RST;
        thr_low = LOW_THR_RST;
        tick_ms = TICK_PERIOD_RST;
        tmo_ms = SLEEP_TIMEOUT_RST;

        // directed table, reset register values
        plan.push_back(row_chk(mk(0, 0, 16'd12000, 0, 0, 0, CMD_NONE),
                               res(MODE_OFF, 0, 0, 0)));
        // sleep request is ignored
        plan.push_back(row_chk(mk(0, 0, 16'd65535, 0, 0, 0, CMD_SLEEP),
                               res(MODE_OFF, 0, 0, 0)));
        // CAN wakeup from off
        plan.push_back(row_chk(mk(0, 0, 16'd12000, 0, 0, 0, CMD_WAKEUP),
                               res(MODE_INIT, 0, 0, 0)));
        // faults do not matter in init
        plan.push_back(row_chk(mk(1, 1, 16'd12000, 1, 1, 1, CMD_NONE),
                               res(MODE_ACTIVE, 0, 0, 0)));
        plan.push_back(row_chk(mk(1, 0, 16'd12000, 0, 0, 0, CMD_NONE),
                               res(MODE_ACTIVE, 1, 1, 0)));
        // battery exactly at fault threshold is low power, not fault
        plan.push_back(row_chk(mk(1, 0, 16'd9000, 0, 0, 0, CMD_NONE),
                               res(MODE_LOW, 1, 1, 0)));
        plan.push_back(row_chk(mk(1, 0, 16'd11499, 0, 0, 0, CMD_NONE),
                               res(MODE_LOW, 1, 0, 0)));
        plan.push_back(row_chk(mk(0, 0, 16'd11500, 0, 0, 0, CMD_NONE),
                               res(MODE_ACTIVE, 1, 0, 0)));
        plan.push_back(row_chk(mk(0, 0, 16'd11500, 0, 0, 0, CMD_NONE),
                               res(MODE_SLEEP, 1, 1, 0)));
        plan.push_back(row_run(mk(0, 0, 16'd11500, 0, 0, 0, CMD_NONE)));
        plan.push_back(row_chk(mk(0, 1, 16'd11500, 0, 0, 0, CMD_NONE),
                               res(MODE_INIT, 0, 0, 0)));
        plan.push_back(row_run(mk(0, 0, 16'd12000, 0, 0, 1, CMD_NONE)));
        plan.push_back(row_chk(mk(1, 0, 16'd12000, 1, 0, 0, CMD_NONE),
                               res(MODE_FAULT, 1, 1, 0)));
        // fault mode ignores wakeup
        plan.push_back(row_chk(mk(1, 1, 16'd12000, 0, 0, 1, CMD_WAKEUP),
                               res(MODE_FAULT, 0, 0, 0)));
        // reset fault clears a latch set in the same tick
        plan.push_back(row_chk(mk(0, 0, 16'd0, 0, 0, 0, CMD_RESET_FAULT),
                               res(MODE_INIT, 0, 0, 0)));
        plan.push_back(row_chk(mk(1, 0, 16'd0, 0, 0, 1, CMD_NONE),
                               res(MODE_ACTIVE, 0, 0, 1)));
        plan.push_back(row_chk(mk(1, 0, 16'd65535, 0, 0, 0, CMD_NONE),
                               res(MODE_FAULT, 1, 1, 1)));
        // reset fault overrides active fault levels, init runs in same tick
        plan.push_back(row_chk(mk(1, 0, 16'd65535, 1, 1, 1, CMD_RESET_FAULT),
                               res(MODE_ACTIVE, 0, 0, 0)));
        plan.push_back(row_run(mk(1, 0, 16'd9000, 0, 0, 0, CMD_NONE)));
        plan.push_back(row_chk(mk(1, 0, 16'd12000, 0, 1, 0, CMD_NONE),
                               res(MODE_FAULT, 1, 0, 0)));
        plan.push_back(row_run(mk(1, 0, 16'd65535, 0, 0, 1, CMD_RESET_FAULT)));
        plan.push_back(row_run(mk(0, 0, 16'd65535, 0, 0, 0, CMD_NONE)));
        // zero sleep timeout: off on the first sleep tick
        plan.push_back(row_cfg(CFG_SLEEP_TIMEOUT, 16'd0));
        plan.push_back(row_chk(mk(0, 0, 16'd65535, 0, 0, 0, CMD_SLEEP),
                               res(MODE_OFF, 0, 0, 0)));
        plan.push_back(row_chk(mk(0, 1, 16'd65535, 0, 0, 0, CMD_NONE),
                               res(MODE_INIT, 0, 0, 0)));
        // zero tick period: the sleep timer holds
        plan.push_back(row_cfg(CFG_TICK_PERIOD, 16'd0));
        plan.push_back(row_cfg(CFG_SLEEP_TIMEOUT, 16'd1));
        plan.push_back(row_run(mk(0, 0, 16'd65535, 0, 0, 1, CMD_NONE)));
        plan.push_back(row_run(mk(0, 0, 16'd65535, 0, 0, 0, CMD_NONE)));
        plan.push_back(row_chk(mk(0, 0, 16'd65535, 0, 0, 0, CMD_NONE),
                               res(MODE_SLEEP, 0, 0, 0)));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                send(plan[i].tk, plan[i].typed, plan[i].res);
        end

        // random phases, each with its own register settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    f_thr = 16'd9000;
                    l_thr = 16'd11500;
                    t_per = 16'd1000;
                    t_out = 16'd5000;
                end
                1:
                begin
                    f_thr = 16'd0;
                    l_thr = 16'd65535;
                    t_per = 16'd1;
                    t_out = 16'd1;
                end
                2:
                begin
                    // inverted thresholds, long timeout
                    f_thr = 16'd65535;
                    l_thr = 16'd0;
                    t_per = 16'd1000;
                    t_out = 16'd65535;
                end
                3:
                begin
                    f_thr = 16'd0;
                    l_thr = 16'd0;
                    t_per = 16'd1000;
                    t_out = 16'd0;
                end
                default:
                begin
                    f_thr = 16'($urandom_range(0, 65535));
                    l_thr = ($urandom_range(0, 1) == 1) ?
                            16'(f_thr + $urandom_range(0, 4000)) :
                            16'($urandom_range(0, 65535));
                    t_per = 16'($urandom_range(1, 1000));
                    t_out = 16'($urandom_range(1, 12 * t_per));
                end
            endcase
            drain();
            write_reg(CFG_FAULT_THR, f_thr);
            write_reg(CFG_LOW_THR, l_thr);
            write_reg(CFG_TICK_PERIOD, t_per);
            write_reg(CFG_SLEEP_TIMEOUT, t_out);
            src_idle_on = (ph % 3 != 1);
            snk_idle_on = (ph % 4 != 2);
            for (int n = 0; n < PHASE_REQS; n++)
                send(draw_tick(), 1'b0, res(MODE_OFF, 0, 0, 0));
        end

        // wind down
        in_valid <= 1'b0;
        while (mode_outputs_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mode_outputs_q.size() != 0)
            err_cnt++;
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pmc_pkg.sv
design/power_mode_controller_core.sv
design/pmc_checker.sv
tb/tb_top.sv
